FILE: hdl/sssp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sssp_pkg;
  localparam int MAX_NODES = 1024;
  localparam int MAX_EDGES = 4096;
  localparam int NODE_AW   = $clog2(MAX_NODES);
  localparam int EDGE_AW   = $clog2(MAX_EDGES);
  localparam int PTR_W     = EDGE_AW + 1;
  localparam int CNT_W     = 11;
  localparam int DIST_W    = 30;
  localparam logic [DIST_W-1:0] DIST_SENTINEL = 30'd1000000007;
  localparam logic [PTR_W-1:0]  EMPTY_PTR     = PTR_W'(MAX_EDGES);

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_RUN   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;
endpackage
`default_nettype wire

FILE: hdl/single_source_shortest_path.sv
// an edge add writes the edge and its list head; a clear empties every list head; a search
//   clears the distances, then for each settled node scans the first node_count nodes and
//   walks its edges, and ends with a last scan, the final read and the result beat
// throughput: one item at a time; a new item is taken once the previous one is finished
// reset: synchronous active low; a clearing pass over the list heads then empties every adjacency list
`timescale 1ns / 1ps
`default_nettype none
module single_source_shortest_path (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire [sssp_pkg::CNT_W-1:0]        cfg_node_count,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire [1:0]                        in_req_type,
  input  wire [sssp_pkg::CNT_W-1:0]        in_edge_from,
  input  wire [sssp_pkg::CNT_W-1:0]        in_edge_to,
  input  wire [sssp_pkg::DIST_W-1:0]       in_edge_weight,
  input  wire [sssp_pkg::CNT_W-1:0]        in_start_node,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [sssp_pkg::DIST_W-1:0]      out_path_length,
  output logic                             out_reachable,
  output logic                             out_edge_overflow
);
  import sssp_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_NFE_CLR = 14'b00000000000010,
    S_ADD_WR  = 14'b00000000000100,
    S_DCLR    = 14'b00000000001000,
    S_START   = 14'b00000000010000,
    S_SCAN    = 14'b00000000100000,
    S_SET     = 14'b00000001000000,
    S_HEAD    = 14'b00000010000000,
    S_E_RD    = 14'b00000100000000,
    S_E_WT    = 14'b00001000000000,
    S_D_UPD   = 14'b00010000000000,
    S_FIN_RD  = 14'b00100000000000,
    S_FIN_WT  = 14'b01000000000000,
    S_OUT     = 14'b10000000000000
  } state_t;

  typedef struct packed {
    logic [NODE_AW-1:0] tgt;
    logic [DIST_W-1:0]  len;
    logic [PTR_W-1:0]   link;
  } edge_t;

  typedef struct packed {
    logic              settled;
    logic [DIST_W-1:0] dval;
  } node_t;

  // memories
  edge_t              edge_mem [MAX_EDGES];
  logic [PTR_W-1:0]   nfe_mem  [MAX_NODES];
  node_t              node_mem [MAX_NODES];

  edge_t              edge_rdata;
  logic [PTR_W-1:0]   nfe_rdata;
  node_t              node_rdata;
  logic [EDGE_AW-1:0] edge_raddr, edge_waddr;
  logic               edge_we;
  edge_t              edge_wdata;
  logic [NODE_AW-1:0] nfe_raddr, nfe_waddr;
  logic               nfe_we;
  logic [PTR_W-1:0]   nfe_wdata;
  logic [NODE_AW-1:0] node_raddr, node_waddr;
  logic               node_we;
  node_t              node_wdata;

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
    edge_rdata <= edge_mem[edge_raddr];
  end
  always_ff @(posedge clk) begin
    if (nfe_we) nfe_mem[nfe_waddr] <= nfe_wdata;
    nfe_rdata <= nfe_mem[nfe_raddr];
  end
  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    node_rdata <= node_mem[node_raddr];
  end

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    node_count_r;
  logic [PTR_W-1:0]    edges_r, edges_nxt;
  logic                ovf_r, ovf_nxt;
  logic [NODE_AW-1:0]  clr_r, clr_nxt;
  logic [NODE_AW-1:0]  from_r, from_nxt, to_r, to_nxt;
  logic [DIST_W-1:0]   w_r, w_nxt;
  logic [CNT_W-1:0]    start_r, start_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    scan_r, scan_nxt;
  logic                pv_r, pv_nxt;
  logic [NODE_AW-1:0]  pidx_r, pidx_nxt;
  logic                found_r, found_nxt;
  logic [NODE_AW-1:0]  best_r, best_nxt;
  logic [DIST_W-1:0]   bestd_r, bestd_nxt;
  logic [PTR_W-1:0]    e_r, e_nxt;
  logic [NODE_AW-1:0]  v_r, v_nxt;
  logic [DIST_W-1:0]   len_r, len_nxt;
  logic [DIST_W-1:0]   res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0]   out_len_r, out_len_nxt;
  logic                out_reach_r, out_reach_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  logic                node_ok;
  logic [DIST_W:0]     cand;

  assign node_ok = (in_edge_from != '0) && (in_edge_from <= CNT_W'(MAX_NODES)) &&
                   (in_edge_to != '0) && (in_edge_to <= CNT_W'(MAX_NODES));
  assign cand    = {1'b0, bestd_r} + {1'b0, len_r};

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_path_length   = out_len_r;
  assign out_reachable     = out_reach_r;
  assign out_edge_overflow = out_ovf_r;

  always_comb begin
    state_nxt     = state_r;
    edges_nxt     = edges_r;
    ovf_nxt       = ovf_r;
    clr_nxt       = clr_r;
    from_nxt      = from_r;
    to_nxt        = to_r;
    w_nxt         = w_r;
    start_nxt     = start_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    pv_nxt        = 1'b0;
    pidx_nxt      = pidx_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    bestd_nxt     = bestd_r;
    e_nxt         = e_r;
    v_nxt         = v_r;
    len_nxt       = len_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_len_nxt   = out_len_r;
    out_reach_nxt = out_reach_r;
    out_ovf_nxt   = out_ovf_r;
    edge_raddr    = e_r[EDGE_AW-1:0];
    edge_we       = 1'b0;
    edge_waddr    = edges_r[EDGE_AW-1:0];
    edge_wdata    = '{tgt: to_r, len: w_r, link: nfe_rdata};
    nfe_raddr     = best_r;
    nfe_we        = 1'b0;
    nfe_waddr     = clr_r;
    nfe_wdata     = EMPTY_PTR;
    node_raddr    = scan_r[NODE_AW-1:0];
    node_we       = 1'b0;
    node_waddr    = clr_r;
    node_wdata    = '{settled: 1'b0, dval: DIST_SENTINEL};

    case (state_r)
      S_IDLE: begin
        nfe_raddr = NODE_AW'(in_edge_from - CNT_W'(1));
        if (in_valid) begin
          case (in_req_type)
            REQ_ADD: begin
              if (node_ok) begin
                if (edges_r == PTR_W'(MAX_EDGES)) begin
                  ovf_nxt = 1'b1;
                end else begin
                  from_nxt  = NODE_AW'(in_edge_from - CNT_W'(1));
                  to_nxt    = NODE_AW'(in_edge_to - CNT_W'(1));
                  w_nxt     = in_edge_weight;
                  state_nxt = S_ADD_WR;
                end
              end
            end
            REQ_RUN: begin
              start_nxt = in_start_node;
              count_nxt = (node_count_r != '0 && node_count_r <= CNT_W'(MAX_NODES)) ?
                          node_count_r : '0;
              clr_nxt   = '0;
              state_nxt = S_DCLR;
            end
            REQ_CLEAR: begin
              edges_nxt = '0;
              ovf_nxt   = 1'b0;
              clr_nxt   = '0;
              state_nxt = S_NFE_CLR;
            end
            default: ;
          endcase
        end
      end
      S_NFE_CLR: begin
        nfe_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == NODE_AW'(MAX_NODES - 1)) state_nxt = S_IDLE;
      end
      S_ADD_WR: begin
        edge_we   = 1'b1;
        nfe_we    = 1'b1;
        nfe_waddr = from_r;
        nfe_wdata = edges_r;
        edges_nxt = edges_r + 1'b1;
        state_nxt = S_IDLE;
      end
      S_DCLR: begin
        node_we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == NODE_AW'(MAX_NODES - 1)) state_nxt = S_START;
      end
      S_START: begin
        node_waddr = NODE_AW'(start_r - CNT_W'(1));
        node_wdata = '{settled: 1'b0, dval: '0};
        node_we    = (start_r != '0) && (start_r <= count_r);
        scan_nxt   = '0;
        found_nxt  = 1'b0;
        bestd_nxt  = DIST_SENTINEL;
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        if (pv_r && !node_rdata.settled && node_rdata.dval < bestd_r) begin
          bestd_nxt = node_rdata.dval;
          best_nxt  = pidx_r;
          found_nxt = 1'b1;
        end
        if (scan_r < count_r) begin
          pv_nxt   = 1'b1;
          pidx_nxt = scan_r[NODE_AW-1:0];
          scan_nxt = scan_r + 1'b1;
        end else if (!pv_r) begin
          state_nxt = found_r ? S_SET : S_FIN_RD;
        end
      end
      S_SET: begin
        node_we    = 1'b1;
        node_waddr = best_r;
        node_wdata = '{settled: 1'b1, dval: bestd_r};
        state_nxt  = S_HEAD;
      end
      S_HEAD: begin
        e_nxt     = nfe_rdata;
        state_nxt = S_E_RD;
      end
      S_E_RD: begin
        if (e_r[PTR_W-1]) begin
          scan_nxt  = '0;
          found_nxt = 1'b0;
          bestd_nxt = DIST_SENTINEL;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_E_WT;
        end
      end
      S_E_WT: begin
        e_nxt      = edge_rdata.link;
        v_nxt      = edge_rdata.tgt;
        len_nxt    = edge_rdata.len;
        node_raddr = edge_rdata.tgt;
        state_nxt  = ({1'b0, edge_rdata.tgt} < count_r) ? S_D_UPD : S_E_RD;
      end
      S_D_UPD: begin
        if (cand < {1'b0, DIST_SENTINEL} && cand < {1'b0, node_rdata.dval}) begin
          node_we    = 1'b1;
          node_waddr = v_r;
          node_wdata = '{settled: node_rdata.settled, dval: cand[DIST_W-1:0]};
        end
        state_nxt = S_E_RD;
      end
      S_FIN_RD: begin
        node_raddr = NODE_AW'(count_r - CNT_W'(1));
        state_nxt  = S_FIN_WT;
      end
      S_FIN_WT: begin
        res_nxt   = (count_r == '0) ? DIST_SENTINEL : node_rdata.dval;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = res_r;
          out_reach_nxt = (res_r < DIST_SENTINEL);
          out_ovf_nxt   = ovf_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_NFE_CLR;
      clr_r        <= '0;
      edges_r      <= '0;
      ovf_r        <= 1'b0;
      node_count_r <= CNT_W'(1);
      pv_r         <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      edges_r      <= edges_nxt;
      ovf_r        <= ovf_nxt;
      if (cfg_we) node_count_r <= cfg_node_count;
      pv_r         <= pv_nxt;
      found_r      <= found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    from_r      <= from_nxt;
    to_r        <= to_nxt;
    w_r         <= w_nxt;
    start_r     <= start_nxt;
    count_r     <= count_nxt;
    scan_r      <= scan_nxt;
    pidx_r      <= pidx_nxt;
    best_r      <= best_nxt;
    bestd_r     <= bestd_nxt;
    e_r         <= e_nxt;
    v_r         <= v_nxt;
    len_r       <= len_nxt;
    res_r       <= res_nxt;
    out_len_r   <= out_len_nxt;
    out_reach_r <= out_reach_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end
endmodule
`default_nettype wire

FILE: hdl/sssp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module sssp_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_stall,
  input wire                          out_valid,
  input wire                          out_stall,
  input wire [sssp_pkg::DIST_W-1:0]   out_path_length,
  input wire                          out_reachable
);
  import sssp_pkg::*;

  // adjacency lists are being emptied straight after reset
  a_reset_clear: assert property (@(posedge clk) $past(!rst_n) |-> in_stall)
    else $error("input taken during post-reset clear");

  a_reach_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_reachable == (out_path_length != DIST_SENTINEL)))
    else $error("reachable flag disagrees with path length");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_path_length <= DIST_SENTINEL))
    else $error("path length above sentinel");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_path_length))
    else $error("stalled result beat changed");
endmodule

bind single_source_shortest_path sssp_checker u_sssp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_path_length (out_path_length),
  .out_reachable   (out_reachable)
);
`default_nettype wire

FILE: tb/tb_single_source_shortest_path.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_single_source_shortest_path;
  import sssp_pkg::*;

  typedef struct {
    logic [DIST_W-1:0] path_length;
    logic              reachable;
    logic              edge_overflow;
  } dist_result_t;

  class path_scoreboard;
    int unsigned  edge_to_node[MAX_EDGES];
    int unsigned  edge_len[MAX_EDGES];
    int unsigned  edge_next[MAX_EDGES];
    int unsigned  first_edge[MAX_NODES];
    int unsigned  stored;
    bit           dropped;
    int unsigned  node_count;
    dist_result_t pending[$];
    int           errors;
    int           searches;

    function void reset_state();
      foreach (first_edge[i]) first_edge[i] = MAX_EDGES;
      stored = 0;
      dropped = 0;
      node_count = 1;
      errors = 0;
      searches = 0;
    endfunction

    function int unsigned shortest(int unsigned start, int unsigned cnt);
      int unsigned node_d[MAX_NODES];
      bit          done[MAX_NODES];
      int unsigned best, bestd, e, guard, v;
      longint unsigned cand;
      foreach (node_d[i]) begin
        node_d[i] = DIST_SENTINEL;
        done[i] = 0;
      end
      if (cnt < 1 || cnt > MAX_NODES) return DIST_SENTINEL;
      if (start == 0 || start > cnt) return DIST_SENTINEL;
      node_d[start-1] = 0;
      forever begin
        best = MAX_NODES;
        bestd = DIST_SENTINEL;
        for (int i = 0; i < cnt; i++)
          if (!done[i] && node_d[i] < bestd) begin
            bestd = node_d[i];
            best = i;
          end
        if (best >= MAX_NODES) break;
        done[best] = 1;
        e = first_edge[best];
        guard = 0;
        while (e < MAX_EDGES && guard < MAX_EDGES) begin
          v = edge_to_node[e];
          if (v < cnt) begin
            cand = longint'(bestd) + edge_len[e];
            if (cand < DIST_SENTINEL && cand < node_d[v]) node_d[v] = 32'(cand);
          end
          e = edge_next[e];
          guard++;
        end
      end
      return node_d[cnt-1];
    endfunction

    function void note_beat(req_t req, int unsigned from, int unsigned dest,
                            int unsigned w, int unsigned start);
      dist_result_t r;
      int unsigned d;
      case (req)
        REQ_ADD: begin
          if (from == 0 || from > MAX_NODES || dest == 0 || dest > MAX_NODES) return;
          if (stored >= MAX_EDGES) begin
            dropped = 1;
            return;
          end
          edge_to_node[stored] = dest - 1;
          edge_len[stored] = w;
          edge_next[stored] = first_edge[from-1];
          first_edge[from-1] = stored;
          stored++;
        end
        REQ_CLEAR: begin
          foreach (first_edge[i]) first_edge[i] = MAX_EDGES;
          stored = 0;
          dropped = 0;
        end
        REQ_RUN: begin
          d = shortest(start, node_count);
          r.path_length = DIST_W'(d);
          r.reachable = (d < DIST_SENTINEL);
          r.edge_overflow = dropped;
          pending.insert(pending.size(), r);
        end
        default: ;
      endcase
    endfunction

    function void check_beat(logic [DIST_W-1:0] pl, logic rc, logic ov);
      dist_result_t x;
      if (pending.size() == 0) begin
        $error("unexpected result beat: path_length %0d", pl);
        errors++;
        return;
      end
      x = pending.pop_front();
      searches++;
      if (pl !== x.path_length) begin
        $error("path_length: expected %0d, got %0d", x.path_length, pl);
        errors++;
      end
      if (rc !== x.reachable) begin
        $error("reachable: expected %0d, got %0d", x.reachable, rc);
        errors++;
      end
      if (ov !== x.edge_overflow) begin
        $error("edge_overflow: expected %0d, got %0d", x.edge_overflow, ov);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               cfg_we = 0;
  logic [CNT_W-1:0]   cfg_node_count = 1;
  logic               in_valid = 0;
  logic               in_stall;
  logic [1:0]         in_req_type = REQ_NONE;
  logic [CNT_W-1:0]   in_edge_from = 0;
  logic [CNT_W-1:0]   in_edge_to = 0;
  logic [DIST_W-1:0]  in_edge_weight = 0;
  logic [CNT_W-1:0]   in_start_node = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [DIST_W-1:0]  out_path_length;
  logic               out_reachable;
  logic               out_edge_overflow;

  path_scoreboard sb = new();
  int send_idle = 0;
  int recv_idle = 0;
  int hold_cycles = 0;
  int beats_sent = 0;

  single_source_shortest_path DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_node_count(cfg_node_count),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_edge_from(in_edge_from), .in_edge_to(in_edge_to),
    .in_edge_weight(in_edge_weight), .in_start_node(in_start_node),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_path_length(out_path_length), .out_reachable(out_reachable),
    .out_edge_overflow(out_edge_overflow)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall)
      sb.check_beat(out_path_length, out_reachable, out_edge_overflow);

  task automatic send_beat(req_t req, int unsigned from, int unsigned dest,
                           int unsigned w, int unsigned start);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_req_type <= req;
    in_edge_from <= CNT_W'(from);
    in_edge_to <= CNT_W'(dest);
    in_edge_weight <= DIST_W'(w);
    in_start_node <= CNT_W'(start);
    do @(posedge clk); while (in_stall);
    sb.note_beat(req, from & 11'h7ff, dest & 11'h7ff, w & 30'h3fffffff, start & 11'h7ff);
    beats_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
  endtask

  task automatic set_count(int unsigned n);
    drain();
    cfg_we <= 1;
    cfg_node_count <= CNT_W'(n);
    @(posedge clk);
    cfg_we <= 0;
    sb.node_count = n & 11'h7ff;
  endtask

  task automatic random_beats(int n, int unsigned span);
    int unsigned p, f, d, w, s;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      f = ($urandom_range(19) == 0) ? $urandom : $urandom_range(1, span);
      d = ($urandom_range(19) == 0) ? $urandom : $urandom_range(1, span);
      case ($urandom_range(9))
        0, 1:    w = $urandom;
        2:       w = $urandom_range(999999990, 1000000010);
        default: w = $urandom_range(0, 50);
      endcase
      s = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, span);
      if (p < 78) send_beat(REQ_ADD, f, d, w, s);
      else if (p < 90) send_beat(REQ_RUN, f, d, w, s);
      else if (p < 94) send_beat(REQ_CLEAR, f, d, w, s);
      else send_beat(REQ_NONE, f, d, w, s);
    end
  endtask

  initial begin
    int unsigned n;
    sb.reset_state();
    repeat (4) @(posedge clk);
    rst_n <= 1;
    repeat (1100) @(posedge clk);

    // directed: extremes, ties, bad nodes, unknown request
    set_count(4);
    send_beat(REQ_ADD, 1, 2, 5, 0);
    send_beat(REQ_ADD, 1, 3, 5, 0);
    send_beat(REQ_ADD, 2, 4, 1, 0);
    send_beat(REQ_ADD, 3, 4, 1, 0);
    send_beat(REQ_ADD, 1, 5, 0, 0);
    send_beat(REQ_ADD, 0, 2, 1, 0);
    send_beat(REQ_ADD, 2047, 2047, 30'h3fffffff, 2047);
    send_beat(REQ_ADD, 4, 1, 30'h3fffffff, 0);
    send_beat(REQ_ADD, 2, 1, 1000000006, 0);
    send_beat(REQ_NONE, 2047, 2047, 30'h3fffffff, 2047);
    send_beat(REQ_RUN, 0, 0, 0, 1);
    send_beat(REQ_RUN, 0, 0, 0, 0);
    send_beat(REQ_RUN, 0, 0, 0, 5);
    send_beat(REQ_RUN, 0, 0, 0, 2047);
    send_beat(REQ_RUN, 0, 0, 0, 4);
    send_beat(REQ_ADD, 1, 4, 1000000007, 0);
    send_beat(REQ_RUN, 0, 0, 0, 1);
    set_count(0);
    send_beat(REQ_RUN, 0, 0, 0, 1);
    set_count(2047);
    send_beat(REQ_RUN, 0, 0, 0, 1);
    set_count(1024);
    send_beat(REQ_CLEAR, 0, 0, 0, 0);
    send_beat(REQ_ADD, 1020, 1024, 7, 0);
    send_beat(REQ_ADD, 1021, 1020, 3, 0);
    send_beat(REQ_RUN, 0, 0, 0, 1021);
    send_beat(REQ_RUN, 0, 0, 0, 1024);
    set_count(1);
    send_beat(REQ_RUN, 0, 0, 0, 1);

    // random phases under each idling pattern
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_idle = 0;  end
        1: begin send_idle = 75; recv_idle = 0;  end
        2: begin send_idle = 0;  recv_idle = 75; end
        default: begin send_idle = 11; recv_idle = 11; end
      endcase
      n = $urandom_range(2, 12);
      set_count(n);
      send_beat(REQ_CLEAR, 0, 0, 0, 0);
      random_beats(200, n + 2);
    end

    // long receiver hold-off while beats keep coming
    send_idle = 0;
    recv_idle = 0;
    hold_cycles = 4000;
    for (int i = 0; i < 6; i++) begin
      send_beat(REQ_ADD, $urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(9), 0);
      send_beat(REQ_RUN, 0, 0, 0, $urandom_range(1, 4));
    end
    drain();
    random_beats(20, 6);

    send_beat(REQ_CLEAR, 0, 0, 0, 0);
    send_beat(REQ_RUN, 0, 0, 0, 1);

    drain();
    $display("%0d input beats sent, %0d search results checked", beats_sent, sb.searches);
    $display("covered node counts 0 to 2047, bad nodes, ties, stalls and hold-offs");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire
